>>> rtl/subtract_with_borrow_prng_core_macros.svh
// Assertion macros shared by the subtract-with-borrow generator.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef SUBTRACT_WITH_BORROW_PRNG_CORE_MACROS_SVH
`define SUBTRACT_WITH_BORROW_PRNG_CORE_MACROS_SVH

// Same-cycle implication.
`define SWB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SWB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/swb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_pkg: shared definitions for the subtract-with-borrow generator
// Lag constants, ring index widths, item codes and the command record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package swb_pkg;

   localparam int LONG_LAG  = 43;
   localparam int SHORT_LAG = 22;
   localparam int WORD_W    = 32;
   localparam int IDX_W     = $clog2(LONG_LAG);

   localparam logic [IDX_W-1:0] LONG_IDX_RESET  = IDX_W'(LONG_LAG - 1);
   localparam logic [IDX_W-1:0] SHORT_IDX_RESET = IDX_W'(SHORT_LAG - 1);
   localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(LONG_LAG - 1);

   localparam logic [WORD_W-1:0] BASE_GAP   = 32'd5;
   localparam logic [WORD_W-1:0] SEED_LIMIT = 32'hFFFF_FFFB;
   localparam logic [WORD_W-1:0] SEED_CLAMP = 32'hFFFF_FFFA;

   localparam logic KIND_SEED = 1'b0;
   localparam logic KIND_GEN  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  wr_idx;
      logic [IDX_W-1:0]  rd_short;
      logic [IDX_W-1:0]  rd_long;
      logic [WORD_W-1:0] seed;
   } cmd_type;

endpackage

>>> rtl/swb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_front: item intake and position tracking
// Accepts seed and generate beats, keeps the three ring positions and turns
// each beat into a command with its ring addresses and conditioned seed.
// ----------------------------------------------------------------------------
module swb_front
   import swb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_kind,
   input  logic [WORD_W-1:0] req_seed_word,
   input  logic              cmd_full,
   output logic              cmd_push,
   output cmd_type           cmd_data
);

   logic [IDX_W-1:0]  long_ff, long_in;
   logic [IDX_W-1:0]  short_ff, short_in;
   logic [IDX_W-1:0]  load_ff, load_in;
   logic [WORD_W-1:0] seed_word;

   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      seed_word = (req_seed_word >= SEED_LIMIT) ? SEED_CLAMP : req_seed_word;
      // A seed word loaded into the first ring entry is always made even.
      if (load_ff == '0) begin
         seed_word[0] = 1'b0;
      end
   end

   always_comb begin
      cmd_data.kind     = req_kind;
      cmd_data.wr_idx   = (req_kind == KIND_SEED) ? load_ff : long_ff;
      cmd_data.rd_short = short_ff;
      cmd_data.rd_long  = long_ff;
      cmd_data.seed     = seed_word;
   end

   always_comb begin
      long_in  = long_ff;
      short_in = short_ff;
      load_in  = load_ff;
      if (cmd_push) begin
         if (req_kind == KIND_SEED) begin
            long_in  = LONG_IDX_RESET;
            short_in = SHORT_IDX_RESET;
            load_in  = (load_ff == LAST_IDX) ? '0 : load_ff + 1'b1;
         end else begin
            long_in  = (long_ff == '0) ? LAST_IDX : long_ff - 1'b1;
            short_in = (short_ff == '0) ? LAST_IDX : short_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= LONG_IDX_RESET;
         short_ff <= SHORT_IDX_RESET;
         load_ff  <= '0;
      end else begin
         long_ff  <= long_in;
         short_ff <= short_in;
         load_ff  <= load_in;
      end
   end

endmodule

>>> rtl/swb_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_cmd_queue: command queue between front end and back end
// A short register queue that lets intake and execution stall independently.
// ----------------------------------------------------------------------------
module swb_cmd_queue
   import swb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/swb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_back: lag ring and subtract-with-borrow datapath
// Issue stage reads both lag words from the ring memory; execute stage forms
// the new word, updates borrow and writes the ring.
// ----------------------------------------------------------------------------
module swb_back
   import swb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_ready,
   output logic              rsp_push,
   output logic [WORD_W-1:0] rsp_word
);

   logic [WORD_W-1:0] ring_mem [LONG_LAG];

   logic              exec_valid_ff, exec_valid_in;
   logic              exec_kind_ff;
   logic [IDX_W-1:0]  exec_wr_idx_ff;
   logic [WORD_W-1:0] exec_seed_ff;
   logic              borrow_ff, borrow_in;

   logic [WORD_W-1:0] rd_short_ff;
   logic [WORD_W-1:0] rd_long_ff;
   logic              byp_short_ff;
   logic              byp_long_ff;
   logic [WORD_W-1:0] byp_data_ff;

   logic              advance;
   logic              exec_done;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] x_short;
   logic [WORD_W-1:0] x_long;
   logic [WORD_W-1:0] diff;
   logic              wrapped;
   logic [WORD_W-1:0] gen_word;

   assign exec_done = exec_valid_ff && ((exec_kind_ff == KIND_SEED) || rsp_ready);
   assign advance   = !exec_valid_ff || exec_done;
   assign cmd_pop   = cmd_valid && advance;
   assign wr_en     = exec_done;

   // A word being written in the same cycle as a read of its entry is
   // forwarded around the memory.
   assign x_short = byp_short_ff ? byp_data_ff : rd_short_ff;
   assign x_long  = byp_long_ff ? byp_data_ff : rd_long_ff;

   always_comb begin
      diff     = x_short - x_long - {{(WORD_W-1){1'b0}}, borrow_ff};
      wrapped  = (x_short < diff);
      gen_word = wrapped ? diff - BASE_GAP : diff;
      wr_data  = (exec_kind_ff == KIND_GEN) ? gen_word : exec_seed_ff;
   end

   assign rsp_push = exec_valid_ff && (exec_kind_ff == KIND_GEN) && rsp_ready;
   assign rsp_word = gen_word;

   always_comb begin
      exec_valid_in = advance ? cmd_valid : exec_valid_ff;
      borrow_in     = borrow_ff;
      if (exec_done) begin
         borrow_in = (exec_kind_ff == KIND_SEED) ? 1'b1 : wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         borrow_ff     <= 1'b1;
      end else begin
         exec_valid_ff <= exec_valid_in;
         borrow_ff     <= borrow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         exec_kind_ff   <= cmd_data.kind;
         exec_wr_idx_ff <= cmd_data.wr_idx;
         exec_seed_ff   <= cmd_data.seed;
         rd_short_ff    <= ring_mem[cmd_data.rd_short];
         rd_long_ff     <= ring_mem[cmd_data.rd_long];
         byp_short_ff   <= wr_en && (exec_wr_idx_ff == cmd_data.rd_short);
         byp_long_ff    <= wr_en && (exec_wr_idx_ff == cmd_data.rd_long);
         byp_data_ff    <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[exec_wr_idx_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/swb_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_rsp_queue: result queue
// Holds generated words until the consumer pops them, so the datapath keeps
// running while a result waits, until the queue is full.
// ----------------------------------------------------------------------------
module swb_rsp_queue
   import swb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WORD_W-1:0] push_word,
   output logic              ready,
   input  logic              pop,
   output logic              empty,
   output logic [WORD_W-1:0] pop_word
);

   logic [WORD_W-1:0] word_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign ready    = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && ready;
   assign do_pop   = pop && !empty;
   assign pop_word = word_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         word_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> rtl/subtract_with_borrow_prng_core.sv
// Path: a generate beat passes the command queue, execute registers and
//   result queue to its output (empty low); seed beats give no result.
// Throughput: one beat per cycle, seed or generate, while the result queue
//   has room, set by the lag ring taking one write and two reads each cycle.
// Reset: synchronous; empties queues, sets borrow, restarts positions. The
//   ring itself is not cleared and must be seeded before generating.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtract_with_borrow_prng_core: lag-43/22 subtract-with-borrow generator
// Front end tracks ring positions and conditions seed words; a command queue
// decouples it from the back end, which owns the 43-word lag ring and the
// borrow bit; a result queue feeds the consumer.
// ----------------------------------------------------------------------------
module subtract_with_borrow_prng_core
   import swb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_kind,
   input  logic [WORD_W-1:0] req_seed_word,
   output logic              empty,
   input  logic              pop,
   output logic [WORD_W-1:0] rsp_random_word
);

`include "subtract_with_borrow_prng_core_macros.svh"

   // The front end owns all three positions, since they depend only on the
   // sequence of item kinds. It resolves the ring addresses of each beat so
   // the back end only has to read, compute and write.
   logic    cmd_push;
   cmd_type cmd_in_data;
   logic    cmd_full;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_out_data;

   // The back end's execute stage pushes one word per generate beat into the
   // result queue and stalls while that queue is full.
   logic              rsp_push;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_word;

   assign full = cmd_full;

   swb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (push),
      .req_kind      (req_kind),
      .req_seed_word (req_seed_word),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_in_data)
   );

   swb_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (cmd_out_data)
   );

   // The ring is read in the issue cycle and written in the execute cycle; a
   // word written while its entry is being read is forwarded, which covers a
   // seed followed at once by a generate that reads the seeded entry.
   swb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_ready (rsp_ready),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   swb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_word),
      .ready     (rsp_ready),
      .pop       (pop),
      .empty     (empty),
      .pop_word  (rsp_random_word)
   );

   // An accepted beat must be waiting for the back end in the next cycle.
   `SWB_ASSERT_NEXT(a_accept_queued, clock, reset, push && !full, cmd_valid, "accepted beat lost")
   // The result queue never drops a word.
   `SWB_ASSERT_NOW(a_rsp_no_overflow, clock, reset, rsp_push, rsp_ready, "result queue overflow")
   // A result appears only after the datapath produced one.
   `SWB_ASSERT_NOW(a_rsp_from_push, clock, reset, $fell(empty), $past(rsp_push), "spurious result")

endmodule

>>> tb/sv/subtract_with_borrow_prng_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtract_with_borrow_prng_core_tb: self-checking bench for the lag-43/22
// subtract-with-borrow generator
// A directed table seeds the lag ring and walks through the clamp, the
// bit-0 rule, reseeding after generation and load position wrap. Random
// phases follow with different idle and stall patterns, including a long
// consumer hold-off that backs the block up. Every generated word is checked
// against a cycle-free generator model in this bench, or a typed row's word.
// ----------------------------------------------------------------------------
module subtract_with_borrow_prng_core_tb;
   import swb_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASES       = 5;
   localparam int DIRECTED_ROWS = 15;

   // One row of the directed table. A row repeats its beat 'beats' times.
   // When 'typed' is set, the word in 'typed_word' is the expected output of
   // every generate beat in that row; otherwise the model supplies it.
   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] word;
      logic [7:0]        beats;
      logic              typed;
      logic [WORD_W-1:0] typed_word;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // First word is odd: bit 0 must be cleared at load position 1.
      '{KIND_SEED, 32'h0000_0001, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'h0000_0000, 8'd42, 1'b0, 32'h0},
      // All-zero ring with the seed borrow: 0 - 0 - 1 wraps, minus the gap.
      '{KIND_GEN,  32'h0000_0000, 8'd22, 1'b1, 32'hFFFF_FFFA},
      // The seed word of a generate beat must be ignored.
      '{KIND_GEN,  32'hFFFF_FFFF, 8'd1,  1'b0, 32'h0},
      '{KIND_GEN,  32'h0000_0000, 8'd20, 1'b0, 32'h0},
      // Reseed after generating; load position has wrapped back to 1.
      '{KIND_SEED, 32'hFFFF_FFFF, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'hFFFF_FFFB, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'hFFFF_FFFA, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'hFFFF_FFF9, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'h8000_0000, 8'd1,  1'b0, 32'h0},
      '{KIND_SEED, 32'h7FFF_FFFF, 8'd1,  1'b0, 32'h0},
      '{KIND_GEN,  32'h0000_0000, 8'd30, 1'b0, 32'h0},
      // A full lap of clamped seeds, wrapping the load position.
      '{KIND_SEED, 32'hFFFF_FFFF, 8'd43, 1'b0, 32'h0},
      '{KIND_GEN,  32'h0000_0000, 8'd22, 1'b1, 32'hFFFF_FFFA},
      '{KIND_GEN,  32'h5555_AAAA, 8'd45, 1'b0, 32'h0}
   };

   // Random phases: beat count, producer idle percent, consumer stall
   // percent. The last phase also holds the consumer off for a long stretch.
   localparam int PHASE_BEATS [PHASES] = '{400, 250, 350, 350, 150};
   localparam int PHASE_IDLE  [PHASES] = '{0,   83,  0,   17,  0};
   localparam int PHASE_STALL [PHASES] = '{0,   0,   83,  17,  0};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic              req_kind = KIND_SEED;
   logic [WORD_W-1:0] req_seed_word = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic [WORD_W-1:0] rsp_random_word;

   logic              hold_kick = 1'b0;
   int unsigned       hold_left = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       cycle_count = 0;
   int unsigned       mismatch_count = 0;

   // Generated words that are still on their way out of the block.
   logic [WORD_W-1:0] pending_words [$];

   // Generator model state. Ring entries are indexed 1..LONG_LAG, as the
   // positions are; ring_seeded tracks which entries hold a defined word.
   logic [WORD_W-1:0] ring_words [1:LONG_LAG];
   bit                ring_seeded [1:LONG_LAG];
   bit                gen_borrow = 1'b1;
   int                long_pos = LONG_LAG;
   int                short_pos = SHORT_LAG;
   int                load_pos = 1;

   subtract_with_borrow_prng_core DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_kind        (req_kind),
      .req_seed_word   (req_seed_word),
      .empty           (empty),
      .pop             (pop),
      .rsp_random_word (rsp_random_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the generator model by one accepted beat. Returns 1 and the
   // new word for a generate beat, 0 for a seed beat.
   function automatic bit step_generator(input logic kind,
                                         input logic [WORD_W-1:0] word,
                                         output logic [WORD_W-1:0] produced);
      logic [WORD_W-1:0] xs;
      logic [WORD_W-1:0] xl;
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] w;
      produced = '0;
      if (kind == KIND_SEED) begin
         w = word;
         if (w >= SEED_LIMIT) begin
            w = SEED_CLAMP;
         end
         // A seed word loaded at position 1 is always forced even.
         if (load_pos == 1) begin
            w[0] = 1'b0;
         end
         ring_words[load_pos] = w;
         ring_seeded[load_pos] = 1'b1;
         load_pos = (load_pos == LONG_LAG) ? 1 : load_pos + 1;
         gen_borrow = 1'b1;
         long_pos = LONG_LAG;
         short_pos = SHORT_LAG;
         return 1'b0;
      end
      xs = ring_words[short_pos];
      xl = ring_words[long_pos];
      t = xs - xl - {{(WORD_W-1){1'b0}}, gen_borrow};
      // A wrap below zero shows up as t above x[short]; the base is
      // 2^32 - 5, so the wrapped difference is pulled down by the gap.
      if (xs < t) begin
         t = t - BASE_GAP;
         gen_borrow = 1'b1;
      end else begin
         gen_borrow = 1'b0;
      end
      ring_words[long_pos] = t;
      long_pos = (long_pos == 1) ? LONG_LAG : long_pos - 1;
      short_pos = (short_pos == 1) ? LONG_LAG : short_pos - 1;
      produced = t;
      return 1'b1;
   endfunction

   // A generate beat is only legal when both ring entries it reads are
   // defined; the ring is not cleared by reset.
   function automatic bit can_generate();
      return ring_seeded[short_pos] && ring_seeded[long_pos];
   endfunction

   // Offers one beat on the input side, after a random number of idle
   // cycles, and waits for the edge that takes it. Called right after a
   // rising edge; push is assigned at most once per edge.
   task automatic send_beat(input logic kind, input logic [WORD_W-1:0] word,
                            input bit typed, input logic [WORD_W-1:0] typed_word);
      logic [WORD_W-1:0] produced;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= kind;
      req_seed_word <= word;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      // Accepted at this edge: push was high and full was low before it.
      if (step_generator(kind, word, produced)) begin
         pending_words.push_back(typed ? typed_word : produced);
      end
   endtask

   // Stimulus: reset, the directed table, then the random phases.
   initial begin
      logic              kind;
      logic [WORD_W-1:0] word;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with no idling on either side.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         for (int b = 0; b < DIRECTED[r].beats; b++) begin
            send_beat(DIRECTED[r].kind, DIRECTED[r].word,
                      DIRECTED[r].typed, DIRECTED[r].typed_word);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         // Let the block drain fully before the next pattern starts.
         push <= 1'b0;
         @(posedge clock);
         while (pending_words.size() != 0) begin
            @(posedge clock);
         end
         send_idle_pct = PHASE_IDLE[p];
         recv_stall_pct = PHASE_STALL[p];
         if (p == PHASES - 1) begin
            // Long consumer hold-off while the producer keeps offering
            // beats back to back, so both queues fill and full rises.
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
         for (int n = 0; n < PHASE_BEATS[p]; n++) begin
            // Mostly generate beats; reseeds restart borrow and positions.
            if (!can_generate() || $urandom_range(99) < 12) begin
               kind = KIND_SEED;
               case ($urandom_range(3))
                  0: word = 32'hFFFF_FFF8 + $urandom_range(7);
                  1: word = $urandom_range(15);
                  default: word = $urandom;
               endcase
            end else begin
               kind = KIND_GEN;
               word = $urandom;
            end
            send_beat(kind, word, 1'b0, '0);
         end
      end

      push <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      // The settle wait catches any word the block emits without cause.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Consumer hold-off counter, loaded by a one-cycle kick.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Consumer side: checks each accepted output beat against the oldest
   // pending word, then decides whether to pop at the next edge.
   always @(posedge clock) begin
      logic [WORD_W-1:0] want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_words.size() == 0) begin
               $error("random_word: no word expected, got %h", rsp_random_word);
               mismatch_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_random_word !== want) begin
                  $error("random_word: expected %h, got %h", want, rsp_random_word);
                  mismatch_count++;
               end
            end
         end
         pop <= (hold_left == 0) && !hold_kick && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Run limit, far above the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
